[rtl/lnr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lnr_pkg;

  // Longest row; a row that reaches it closes without a row_end flag.
  localparam int unsigned RowLen  = 64;
  localparam int unsigned AddrW   = $clog2(RowLen);
  localparam int unsigned CountW  = AddrW + 1;
  localparam int unsigned DataW   = 16;

  // Iteration counts of the shared divider and of the square root unit.
  localparam int unsigned VarDivSteps   = 51;
  localparam int unsigned RecipDivSteps = 57;
  localparam int unsigned OutDivSteps   = 25;
  localparam int unsigned SqrtSteps     = 29;

  typedef enum logic [16:0] {
    ST_IDLE  = 17'b00000000000000001,
    ST_CUBE1 = 17'b00000000000000010,
    ST_CUBE2 = 17'b00000000000000100,
    ST_VRD   = 17'b00000000000001000,
    ST_VC    = 17'b00000000000010000,
    ST_VSQ   = 17'b00000000000100000,
    ST_VACC  = 17'b00000000001000000,
    ST_DIV   = 17'b00000000010000000,
    ST_VLD   = 17'b00000000100000000,
    ST_SQL   = 17'b00000001000000000,
    ST_SQRT  = 17'b00000010000000000,
    ST_ORD   = 17'b00000100000000000,
    ST_OC    = 17'b00001000000000000,
    ST_OM1   = 17'b00010000000000000,
    ST_OM2   = 17'b00100000000000000,
    ST_ORND  = 17'b01000000000000000,
    ST_OFIN  = 17'b10000000000000000
  } state_e;

  typedef enum logic [1:0] {
    PH_VAR   = 2'd0,
    PH_RECIP = 2'd1,
    PH_OUT   = 2'd2
  } div_phase_e;

endpackage

`default_nettype wire

[rtl/layer_norm_row.sv]
`timescale 1ns / 1ps
`default_nettype none

// Layer normalization of one row of up to 64 signed Q8.8 elements. Each input word carries
// one element, its Q4.12 gain and its Q8.8 bias; row_end_i closes the row, and a row that
// reaches 64 elements closes by itself. Input words of a row are taken one per cycle. When
// the row closes, the block computes the mean and population variance, adds epsilon (units
// of 2^-16), takes the reciprocal square root, and then returns one Q8.8 result per
// element in arrival order, rounded half away from zero and saturated, with out_last_o on
// the final one. The closing work forms n cubed, makes a variance pass that reads, centres,
// squares and accumulates each element, runs a 51-step and a 57-step pass of the shared
// restoring divider and a 29-step square root, with a setup state before the second
// division and one before the square root, and for every result reads, multiplies twice,
// rounds and hands off around a 25-step pass of the same divider. The block takes no input
// word during the closing work; it takes the first word of the next row while the last
// result still waits.
// Epsilon is written through cfg_we_i and should change only while the block is idle.

module layer_norm_row (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [15:0]  sample_i,
  input  logic signed [15:0]  scale_i,
  input  logic signed [15:0]  shift_i,
  input  logic                row_end_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [15:0]  normalized_o,
  output logic                out_last_o
);
  import lnr_pkg::*;

  // Row store: one word per element holding shift, scale and sample.
  logic [3*DataW-1:0] mem [RowLen];
  logic [3*DataW-1:0] rdata_q;
  logic               mem_we;
  logic               rd_en;

  state_e              state_q, state_d;
  div_phase_e          phase_q, phase_d;
  logic [CountW-1:0]   cnt_q, cnt_d;
  logic [CountW-1:0]   n_q, n_d;
  logic [AddrW-1:0]    j_q, j_d;
  logic signed [22:0]  sum_q, sum_d;
  logic [15:0]         eps_q;
  logic [5:0]          it_q, it_d;
  logic                ov_q, ov_d;

  logic [18:0]         cube_q, cube_d;
  logic signed [23:0]  c_q, c_d;
  logic [44:0]         sq_q, sq_d;
  logic [50:0]         acc_q, acc_d;
  logic [56:0]         dvd_q, dvd_d;
  logic [31:0]         dvs_q, dvs_d;
  logic [31:0]         rem_q, rem_d;
  logic [56:0]         quot_q, quot_d;
  logic [57:0]         sqa_q, sqa_d;
  logic [31:0]         srem_q, srem_d;
  logic [28:0]         r_q, r_d;
  logic signed [15:0]  scl_q, scl_d;
  logic signed [15:0]  shf_q, shf_d;
  logic signed [39:0]  cr_q, cr_d;
  logic signed [55:0]  p_q, p_d;
  logic                neg_q, neg_d;
  logic signed [15:0]  onorm_q, onorm_d;
  logic                olast_q, olast_d;

  // Shared datapath pieces.
  logic signed [7:0]   n_s;
  logic signed [15:0]  x_s;
  logic signed [23:0]  nx;
  logic signed [23:0]  c_new;
  logic signed [47:0]  sqf;
  logic [50:0]         acc_sum;
  logic signed [52:0]  crf;
  logic signed [55:0]  pf;
  logic [55:0]         mag;
  logic [56:0]         rnd;
  logic [13:0]         nsq;
  logic [18:0]         ncube;
  logic [32:0]         div_sh;
  logic [33:0]         sq_sh;
  logic [33:0]         sq_trial;
  logic [31:0]         v_sum;
  logic signed [25:0]  q_mag;
  logic signed [25:0]  q_sgn;
  logic signed [25:0]  y_sum;
  logic signed [15:0]  y_sat;
  logic                in_acc;
  logic                out_free;
  logic                last_elem;

  assign in_stall_o   = (state_q != ST_IDLE);
  assign in_acc       = in_valid_i && (state_q == ST_IDLE);
  assign out_free     = !ov_q || !out_stall_i;
  assign out_valid_o  = ov_q;
  assign normalized_o = onorm_q;
  assign out_last_o   = olast_q;

  assign n_s       = signed'({1'b0, n_q});
  assign x_s       = signed'(rdata_q[DataW-1:0]);
  assign nx        = n_s * x_s;
  // Deviation from the mean, scaled by n so that it stays an exact integer.
  assign c_new     = nx - 24'(sum_q);
  assign sqf       = c_q * c_q;
  assign acc_sum   = acc_q + {6'b0, sq_q};
  assign crf       = c_q * signed'({1'b0, r_q});
  assign pf        = cr_q * scl_q;
  assign mag       = p_q[55] ? (~p_q + 56'd1) : p_q;
  assign rnd       = {1'b0, mag} + {19'b0, n_q, 31'b0};
  assign nsq       = n_q * n_q;
  assign ncube     = cube_q * {12'b0, n_q};
  assign last_elem = (j_q == AddrW'(n_q - CountW'(1)));

  assign div_sh    = {rem_q, dvd_q[56]};
  assign sq_sh     = {srem_q, sqa_q[57:56]};
  assign sq_trial  = {3'b0, r_q, 2'b01};
  assign v_sum     = quot_q[31:0] + {16'b0, eps_q};

  assign q_mag = signed'({1'b0, quot_q[24:0]});
  assign q_sgn = neg_q ? -q_mag : q_mag;
  assign y_sum = q_sgn + 26'(shf_q);

  always_comb begin
    if (y_sum > 26'sd32767) begin
      y_sat = 16'sh7fff;
    end else if (y_sum < -26'sd32768) begin
      y_sat = -16'sh8000;
    end else begin
      y_sat = y_sum[15:0];
    end
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    n_d     = n_q;
    j_d     = j_q;
    sum_d   = sum_q;
    it_d    = it_q;
    ov_d    = ov_q && out_stall_i;
    cube_d  = cube_q;
    c_d     = c_q;
    sq_d    = sq_q;
    acc_d   = acc_q;
    dvd_d   = dvd_q;
    dvs_d   = dvs_q;
    rem_d   = rem_q;
    quot_d  = quot_q;
    sqa_d   = sqa_q;
    srem_d  = srem_q;
    r_d     = r_q;
    scl_d   = scl_q;
    shf_d   = shf_q;
    cr_d    = cr_q;
    p_d     = p_q;
    neg_d   = neg_q;
    onorm_d = onorm_q;
    olast_d = olast_q;
    mem_we  = 1'b0;
    rd_en   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          mem_we = 1'b1;
          sum_d  = sum_q + 23'(sample_i);
          if (row_end_i || (cnt_q == CountW'(RowLen - 1))) begin
            n_d     = cnt_q + CountW'(1);
            cnt_d   = '0;
            state_d = ST_CUBE1;
          end else begin
            cnt_d = cnt_q + CountW'(1);
          end
        end
      end
      ST_CUBE1: begin
        cube_d  = {5'b0, nsq};
        state_d = ST_CUBE2;
      end
      ST_CUBE2: begin
        cube_d  = ncube;
        acc_d   = '0;
        j_d     = '0;
        state_d = ST_VRD;
      end
      ST_VRD: begin
        rd_en   = 1'b1;
        state_d = ST_VC;
      end
      ST_VC: begin
        c_d     = c_new;
        state_d = ST_VSQ;
      end
      ST_VSQ: begin
        sq_d    = sqf[44:0];
        state_d = ST_VACC;
      end
      ST_VACC: begin
        acc_d = acc_sum;
        if (last_elem) begin
          // Sum of squares over n^3 gives the variance in units of 2^-16.
          dvd_d   = {acc_sum, 6'b0};
          dvs_d   = {13'b0, cube_q};
          rem_d   = '0;
          quot_d  = '0;
          it_d    = 6'(VarDivSteps);
          phase_d = PH_VAR;
          state_d = ST_DIV;
        end else begin
          j_d     = j_q + AddrW'(1);
          state_d = ST_VRD;
        end
      end
      ST_DIV: begin
        // One restoring step: bring down a dividend bit, subtract if it fits.
        if (div_sh >= {1'b0, dvs_q}) begin
          rem_d  = 32'(div_sh - {1'b0, dvs_q});
          quot_d = {quot_q[55:0], 1'b1};
        end else begin
          rem_d  = div_sh[31:0];
          quot_d = {quot_q[55:0], 1'b0};
        end
        dvd_d = {dvd_q[55:0], 1'b0};
        it_d  = it_q - 6'd1;
        if (it_q == 6'd1) begin
          case (phase_q)
            PH_VAR:   state_d = ST_VLD;
            PH_RECIP: state_d = ST_SQL;
            default:  state_d = ST_OFIN;
          endcase
        end
      end
      ST_VLD: begin
        // A zero variance with zero epsilon is raised to one.
        dvs_d   = (v_sum == 32'd0) ? 32'd1 : v_sum;
        dvd_d   = {1'b1, 56'b0};
        rem_d   = '0;
        quot_d  = '0;
        it_d    = 6'(RecipDivSteps);
        phase_d = PH_RECIP;
        state_d = ST_DIV;
      end
      ST_SQL: begin
        sqa_d   = {1'b0, quot_q};
        srem_d  = '0;
        r_d     = '0;
        it_d    = 6'(SqrtSteps);
        state_d = ST_SQRT;
      end
      ST_SQRT: begin
        // Digit-by-digit square root, two operand bits per step.
        if (sq_sh >= sq_trial) begin
          srem_d = 32'(sq_sh - sq_trial);
          r_d    = {r_q[27:0], 1'b1};
        end else begin
          srem_d = sq_sh[31:0];
          r_d    = {r_q[27:0], 1'b0};
        end
        sqa_d = {sqa_q[55:0], 2'b00};
        it_d  = it_q - 6'd1;
        if (it_q == 6'd1) begin
          j_d     = '0;
          state_d = ST_ORD;
        end
      end
      ST_ORD: begin
        rd_en   = 1'b1;
        state_d = ST_OC;
      end
      ST_OC: begin
        c_d     = c_new;
        scl_d   = signed'(rdata_q[2*DataW-1:DataW]);
        shf_d   = signed'(rdata_q[3*DataW-1:2*DataW]);
        state_d = ST_OM1;
      end
      ST_OM1: begin
        cr_d    = crf[39:0];
        state_d = ST_OM2;
      end
      ST_OM2: begin
        p_d     = pf;
        state_d = ST_ORND;
      end
      ST_ORND: begin
        // Add half of n * 2^32, drop 32 bits, then divide the rest by n.
        neg_d   = p_q[55];
        dvd_d   = {rnd[56:32], 32'b0};
        dvs_d   = {25'b0, n_q};
        rem_d   = '0;
        quot_d  = '0;
        it_d    = 6'(OutDivSteps);
        phase_d = PH_OUT;
        state_d = ST_DIV;
      end
      ST_OFIN: begin
        if (out_free) begin
          ov_d    = 1'b1;
          onorm_d = y_sat;
          olast_d = last_elem;
          if (last_elem) begin
            sum_d   = '0;
            state_d = ST_IDLE;
          end else begin
            j_d     = j_q + AddrW'(1);
            state_d = ST_ORD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cnt_q[AddrW-1:0]] <= {shift_i, scale_i, sample_i};
    end
    if (rd_en) begin
      rdata_q <= mem[j_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_VAR;
      cnt_q   <= '0;
      n_q     <= '0;
      j_q     <= '0;
      sum_q   <= '0;
      it_q    <= '0;
      ov_q    <= 1'b0;
      eps_q   <= 16'd1;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      n_q     <= n_d;
      j_q     <= j_d;
      sum_q   <= sum_d;
      it_q    <= it_d;
      ov_q    <= ov_d;
      if (cfg_we_i) begin
        eps_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cube_q  <= cube_d;
    c_q     <= c_d;
    sq_q    <= sq_d;
    acc_q   <= acc_d;
    dvd_q   <= dvd_d;
    dvs_q   <= dvs_d;
    rem_q   <= rem_d;
    quot_q  <= quot_d;
    sqa_q   <= sqa_d;
    srem_q  <= srem_d;
    r_q     <= r_d;
    scl_q   <= scl_d;
    shf_q   <= shf_d;
    cr_q    <= cr_d;
    p_q     <= p_d;
    neg_q   <= neg_d;
    onorm_q <= onorm_d;
    olast_q <= olast_d;
  end

endmodule

`default_nettype wire
